// ===== rtl/bto_pkg.sv =====
`default_nettype none

package bto_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_DOT_SCALE    = 3'd2,
		REG_TEXT_CHARS   = 3'd3,
		REG_TEXT_LENGTH  = 3'd4,
		REG_TEXT_COLOR   = 3'd5,
		REG_FRAME_WIDTH  = 3'd6,
		REG_FRAME_HEIGHT = 3'd7
	} cfg_reg_t;

	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int CELL_COLS  = 6;

	localparam logic [5:0] GLYPH_BLANK   = 6'd0;
	localparam logic [5:0] GLYPH_DIGIT0  = 6'd1;
	localparam logic [5:0] GLYPH_LETTERA = 6'd11;
	localparam logic [5:0] GLYPH_PERCENT = 6'd37;
	localparam logic [5:0] GLYPH_PERIOD  = 6'd38;

	typedef struct packed {
		logic [12:0] origin_x;
		logic [12:0] origin_y;
		logic [3:0]  dot_scale;
		logic [63:0] text_chars;
		logic [3:0]  text_length;
		logic [23:0] text_color;
		logic [12:0] frame_width;
		logic [12:0] frame_height;
	} cfg_t;

	// pixel located within the text line: cell index, glyph row, offset from line origin
	typedef struct packed {
		logic [13:0] dx;
		logic [2:0]  char_idx;
		logic [2:0]  row;
		logic        draw;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} loc_t;

	function automatic logic [5:0] char_glyph(input logic [7:0] code);
		logic [5:0] g;
		g = GLYPH_BLANK;
		if (code >= 8'h30 && code <= 8'h39)
			g = GLYPH_DIGIT0 + 6'(code - 8'h30);
		else if (code >= 8'h41 && code <= 8'h5A)
			g = GLYPH_LETTERA + 6'(code - 8'h41);
		else if (code >= 8'h61 && code <= 8'h7A)
			g = GLYPH_LETTERA + 6'(code - 8'h61);
		else if (code == 8'h25)
			g = GLYPH_PERCENT;
		else if (code == 8'h2E)
			g = GLYPH_PERIOD;
		return g;
	endfunction

	// 5x7 font, top row in the high bits, leftmost dot in bit 4 of each row
	function automatic logic [4:0] glyph_row(input logic [5:0] g, input logic [2:0] r);
		logic [34:0] b;
		logic [4:0]  d;
		case (g)
			6'd1:  b = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
			6'd2:  b = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
			6'd3:  b = {5'h0E,5'h11,5'h01,5'h06,5'h08,5'h10,5'h1F};
			6'd4:  b = {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E};
			6'd5:  b = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
			6'd6:  b = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
			6'd7:  b = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E};
			6'd8:  b = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
			6'd9:  b = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
			6'd10: b = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C};
			6'd11: b = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			6'd12: b = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
			6'd13: b = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
			6'd14: b = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
			6'd15: b = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
			6'd16: b = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
			6'd17: b = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
			6'd18: b = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
			6'd19: b = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
			6'd20: b = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C};
			6'd21: b = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
			6'd22: b = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
			6'd23: b = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
			6'd24: b = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
			6'd25: b = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			6'd26: b = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
			6'd27: b = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
			6'd28: b = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
			6'd29: b = {5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E};
			6'd30: b = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
			6'd31: b = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
			6'd32: b = {5'h11,5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04};
			6'd33: b = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
			6'd34: b = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
			6'd35: b = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
			6'd36: b = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
			6'd37: b = {5'h12,5'h05,5'h02,5'h04,5'h0A,5'h14,5'h09};
			6'd38: b = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C};
			default: b = '0;
		endcase
		case (r)
			3'd0: d = b[34:30];
			3'd1: d = b[29:25];
			3'd2: d = b[24:20];
			3'd3: d = b[19:15];
			3'd4: d = b[14:10];
			3'd5: d = b[9:5];
			3'd6: d = b[4:0];
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bto_locate.sv =====
`default_nettype none

module bto_locate #(
	parameter int MAX_CHARS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire bto_pkg::cfg_t cfg,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [11:0]  pixel_x,
	input  wire logic [11:0]  pixel_y,
	input  wire logic [7:0]   in_red,
	input  wire logic [7:0]   in_green,
	input  wire logic [7:0]   in_blue,
	output logic              loc_valid,
	input  wire logic         loc_ready,
	output bto_pkg::loc_t     loc
);
	import bto_pkg::*;

	localparam logic [3:0] MAX_N = 4'(MAX_CHARS);

	logic        en1, en2;
	logic        v_s1, v_s2;
	logic [13:0] dx_s1, dy_s1;
	logic        inframe_s1;
	logic [7:0]  red_s1, green_s1, blue_s1;
	loc_t        loc_s2;

	logic [13:0] dx_c, dy_c;
	logic [6:0]  pitch;
	logic [3:0]  n_eff;
	logic [2:0]  cell_c, row_c;
	logic        rowok_c, cellok_c;

	assign en2      = !v_s2 || loc_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign dx_c = 14'($signed({2'b00, pixel_x}) - $signed({cfg.origin_x[12], cfg.origin_x}));
	assign dy_c = 14'($signed({2'b00, pixel_y}) - $signed({cfg.origin_y[12], cfg.origin_y}));

	assign pitch = 7'(cfg.dot_scale * 7'(CELL_COLS));
	assign n_eff = (cfg.text_length > MAX_N) ? MAX_N : cfg.text_length;

	always_comb begin
		logic [9:0] m;
		logic [6:0] r;
		cell_c = '0;
		for (int j = 1; j < MAX_CHARS; j++) begin
			m = 10'(pitch) * 10'(j);
			if ($signed(dx_s1) >= $signed({4'b0000, m}))
				cell_c = cell_c + 3'd1;
		end
		row_c = '0;
		for (int j = 1; j < GLYPH_ROWS; j++) begin
			r = 7'(cfg.dot_scale) * 7'(j);
			if ($signed(dy_s1) >= $signed({7'b0000000, r}))
				row_c = row_c + 3'd1;
		end
		r = 7'(cfg.dot_scale) * 7'(GLYPH_ROWS);
		rowok_c  = !dy_s1[13] && ($signed(dy_s1) < $signed({7'b0000000, r}));
		cellok_c = !dx_s1[13] && ({1'b0, cell_c} < n_eff) && (cfg.dot_scale != 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1      <= dx_c;
			dy_s1      <= dy_c;
			inframe_s1 <= ({1'b0, pixel_x} < cfg.frame_width) &&
			              ({1'b0, pixel_y} < cfg.frame_height);
			red_s1     <= in_red;
			green_s1   <= in_green;
			blue_s1    <= in_blue;
		end
		if (en2) begin
			loc_s2.dx       <= dx_s1;
			loc_s2.char_idx <= cell_c;
			loc_s2.row      <= row_c;
			loc_s2.draw     <= inframe_s1 && rowok_c && cellok_c;
			loc_s2.red      <= red_s1;
			loc_s2.green    <= green_s1;
			loc_s2.blue     <= blue_s1;
		end
	end

	assign loc_valid = v_s2;
	assign loc       = loc_s2;

endmodule

`default_nettype wire

// ===== rtl/bto_glyph.sv =====
`default_nettype none

module bto_glyph (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bto_pkg::cfg_t cfg,
	input  wire logic          loc_valid,
	output logic               loc_ready,
	input  wire bto_pkg::loc_t loc,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic               text_hit
);
	import bto_pkg::*;

	logic        en3, en4;
	logic        v_s3, v_s4;
	logic [13:0] dxc_s3;
	logic [4:0]  bits_s3;
	logic        draw_s3;
	logic [7:0]  red_s3, green_s3, blue_s3;
	logic [7:0]  red_s4, green_s4, blue_s4;
	logic        hit_s4;

	logic [9:0]  cell_off;
	logic [13:0] dxc_c;
	logic [7:0]  code_c;
	logic [4:0]  bits_c;
	logic [6:0]  pitch;
	logic [2:0]  col_c;
	logic        colok_c, hit_c;

	assign en4       = !v_s4 || out_ready;
	assign en3       = !v_s3 || en4;
	assign loc_ready = en3;

	assign pitch    = 7'(cfg.dot_scale * 7'(CELL_COLS));
	assign cell_off = 10'(loc.char_idx) * 10'(pitch);
	assign dxc_c    = loc.dx - {4'b0000, cell_off};
	assign code_c   = cfg.text_chars[{loc.char_idx, 3'b000} +: 8];
	assign bits_c   = glyph_row(char_glyph(code_c), loc.row);

	always_comb begin
		logic [6:0] m;
		col_c = '0;
		for (int j = 1; j < GLYPH_COLS; j++) begin
			m = 7'(cfg.dot_scale) * 7'(j);
			if ($signed(dxc_s3) >= $signed({7'b0000000, m}))
				col_c = col_c + 3'd1;
		end
		m = 7'(cfg.dot_scale) * 7'(GLYPH_COLS);
		colok_c = !dxc_s3[13] && ($signed(dxc_s3) < $signed({7'b0000000, m}));
		hit_c   = draw_s3 && colok_c && bits_s3[3'd4 - col_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en3)
				v_s3 <= loc_valid;
			if (en4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			dxc_s3   <= dxc_c;
			bits_s3  <= bits_c;
			draw_s3  <= loc.draw;
			red_s3   <= loc.red;
			green_s3 <= loc.green;
			blue_s3  <= loc.blue;
		end
		if (en4) begin
			hit_s4   <= hit_c;
			red_s4   <= hit_c ? cfg.text_color[23:16] : red_s3;
			green_s4 <= hit_c ? cfg.text_color[15:8]  : green_s3;
			blue_s4  <= hit_c ? cfg.text_color[7:0]   : blue_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_red   = red_s4;
	assign out_green = green_s4;
	assign out_blue  = blue_s4;
	assign text_hit  = hit_s4;

endmodule

`default_nettype wire

// ===== rtl/bitmap_text_overlay_core.sv =====
// channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------------
// pixel   | in        | in_valid/in_ready   | pixel_x, pixel_y, in_red, in_green, in_blue
// result  | out       | out_valid/out_ready | out_red, out_green, out_blue, text_hit
// config  | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per clock unless out_ready stalls; stages: position, cell/row find, glyph
// fetch, column pick. Each stage holds while the stage after it is full and stalled;
// bubbles collapse. Reset clears stage valid bits and loads register defaults; cfg_ready
// is always high. Registers are to be written only while the pipeline is empty; unchecked.
`default_nettype none

module bitmap_text_overlay_core #(
	parameter int MAX_CHARS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] pixel_x,
	input  wire logic [11:0] pixel_y,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             text_hit,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [bto_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import bto_pkg::*;

	cfg_t cfg_q;
	loc_t loc;
	logic loc_valid, loc_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.dot_scale    <= 4'd2;
			cfg_q.text_chars   <= '0;
			cfg_q.text_length  <= '0;
			cfg_q.text_color   <= 24'hFFFFFF;
			cfg_q.frame_width  <= 13'd1920;
			cfg_q.frame_height <= 13'd1080;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:     cfg_q.origin_x     <= cfg_data[12:0];
				REG_ORIGIN_Y:     cfg_q.origin_y     <= cfg_data[12:0];
				REG_DOT_SCALE:    cfg_q.dot_scale    <= cfg_data[3:0];
				REG_TEXT_CHARS:   cfg_q.text_chars   <= cfg_data;
				REG_TEXT_LENGTH:  cfg_q.text_length  <= cfg_data[3:0];
				REG_TEXT_COLOR:   cfg_q.text_color   <= cfg_data[23:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[12:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	bto_locate #(
		.MAX_CHARS(MAX_CHARS)
	) u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.loc_valid (loc_valid),
		.loc_ready (loc_ready),
		.loc       (loc)
	);

	bto_glyph u_glyph (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.loc_valid (loc_valid),
		.loc_ready (loc_ready),
		.loc       (loc),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.text_hit  (text_hit)
	);

endmodule

`default_nettype wire

// ===== rtl/bto_checker.sv =====
`default_nettype none

module bto_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  out_red,
	input wire logic [7:0]  out_green,
	input wire logic [7:0]  out_blue,
	input wire logic        text_hit
);
	logic [2:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_acc && !out_acc)
			inflight_q <= inflight_q + 3'd1;
		else if (out_acc && !in_acc)
			inflight_q <= inflight_q - 3'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_red, out_green, out_blue, text_hit}))
		else $error("result changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more requests in flight than stages");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result without a request");

endmodule

bind bitmap_text_overlay_core bto_checker u_bto_checker (.*);

`default_nettype wire
